// File: hw/rtl/dvr_pkg.sv
// Shared types, constants and helpers of the Doppler velocity residual block.
`default_nettype none
package dvr_pkg;

  localparam int DATA_W   = 32;            // port word width
  localparam int FRAC_W   = 16;            // fraction bits of every word
  localparam int MAG_W    = 30;            // normalized magnitude, top bit at MAG_W-1
  localparam int SUM_W    = 2 * MAG_W + 2; // sum of three squares
  localparam int SQ_W     = SUM_W + 1;     // square root working width
  localparam int ROOT_W   = MAG_W + 1;     // floor(sqrt(sum))
  localparam int QUO_W    = FRAC_W + 2;    // direction quotient bits
  localparam int DIR_W    = QUO_W;         // signed direction component
  localparam int CROSS_W  = FRAC_W + 4;    // signed offset cross direction
  localparam int MOUNT_W  = FRAC_W + 3;    // signed mount offset component
  localparam int ADDR_W   = 5;             // byte address of six 32-bit registers

  localparam int SQRT_STAGES = 8;
  localparam int SQRT_STEPS  = 4;          // SQRT_STAGES * SQRT_STEPS = SQ_W / 2 + 1
  localparam int DIV_STAGES  = 6;
  localparam int DIV_STEPS   = 3;          // DIV_STAGES * DIV_STEPS = QUO_W

  // sensor mount offset, meters, rounded to FRAC_W fraction bits
  localparam logic signed [MOUNT_W-1:0] MOUNT_X = 19'sd93061;
  localparam logic signed [MOUNT_W-1:0] MOUNT_Y = 19'sd15729;
  localparam logic signed [MOUNT_W-1:0] MOUNT_Z = 19'sd89784;

  typedef enum logic [2:0] {
    REG_LIN_VEL_X,
    REG_LIN_VEL_Y,
    REG_LIN_VEL_Z,
    REG_ANG_VEL_X,
    REG_ANG_VEL_Y,
    REG_ANG_VEL_Z
  } cfg_reg_t;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t meas;
  } point_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    vec_t lin;
    vec_t ang;
  } vel_t;

  // side band that rides along the pipeline
  typedef struct packed {
    word_t      meas;
    logic [2:0] neg;
    logic       zero;
  } tag_t;

  typedef struct packed {
    tag_t                   tag;
    logic [2:0][MAG_W-1:0]  mag;
    logic [SUM_W-1:0]       sum;
  } norm_t;

  typedef struct packed {
    tag_t                   tag;
    logic [2:0][MAG_W-1:0]  mag;
    logic [ROOT_W-1:0]      root;
  } root_t;

  typedef struct packed {
    tag_t                   tag;
    logic [2:0][DIR_W-1:0]  dir;
  } dir_t;

  typedef struct packed {
    word_t residual;
    word_t rot_x;
    word_t rot_y;
    word_t rot_z;
    word_t trans_x;
    word_t trans_y;
    word_t trans_z;
  } result_t;

  function automatic word_t saturate(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/point_if.sv
// Input channel: one lidar point and its measured speed per transfer.
`default_nettype none
interface point_if;
  import dvr_pkg::*;
  logic  valid;
  logic  ready;
  word_t point_x;
  word_t point_y;
  word_t point_z;
  word_t measured_speed;
  modport source(output valid, point_x, point_y, point_z, measured_speed, input ready);
  modport sink(input valid, point_x, point_y, point_z, measured_speed, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/result_if.sv
// Output channel: residual and Jacobian of one point per transfer.
`default_nettype none
interface result_if;
  import dvr_pkg::*;
  logic  valid;
  logic  ready;
  word_t speed_residual;
  word_t jac_rot_x;
  word_t jac_rot_y;
  word_t jac_rot_z;
  word_t jac_trans_x;
  word_t jac_trans_y;
  word_t jac_trans_z;
  modport source(output valid, speed_residual, jac_rot_x, jac_rot_y, jac_rot_z,
                 jac_trans_x, jac_trans_y, jac_trans_z, input ready);
  modport sink(input valid, speed_residual, jac_rot_x, jac_rot_y, jac_rot_z,
               jac_trans_x, jac_trans_y, jac_trans_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/doppler_velocity_residual_top.sv
// Top level of the Doppler radial-velocity residual and Jacobian pipeline.
//
//  channel   kind            transfer holds
//  points    valid/ready in  point_x, point_y, point_z, measured_speed
//  results   valid/ready out speed_residual, jac_rot_xyz, jac_trans_xyz
//  apb       psel/penable    six velocity registers at 4*i, reads return value
//
// One point per cycle while results are not stalled; the stages are 4 normalize,
// 8 square root, 6 divide and 6 predict. The square root and divider stages set the depth.
// rst is synchronous: it clears every valid bit and the velocity registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// The zero point travels as a bubble and gives no transfer on results.
`default_nettype none
module doppler_velocity_residual_top (
  input  logic                       clk,
  input  logic                       rst,
  point_if.sink                      points,
  result_if.source                   results,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dvr_pkg::ADDR_W-1:0] paddr,
  input  logic [dvr_pkg::DATA_W-1:0] pwdata,
  output logic [dvr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import dvr_pkg::*;

  logic    en;
  vel_t    vel;
  point_t  pt;
  logic    norm_valid, root_valid, dir_valid, res_valid;
  norm_t   norm_data;
  root_t   root_data;
  dir_t    dir_data;
  result_t res_data;

  // pipeline advances unless a finished result is waiting
  assign en           = !res_valid || results.ready;
  assign points.ready = en;

  assign pt.x    = points.point_x;
  assign pt.y    = points.point_y;
  assign pt.z    = points.point_z;
  assign pt.meas = points.measured_speed;

  dvr_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .vel(vel)
  );

  dvr_norm u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(points.valid), .pt(pt),
    .out_valid(norm_valid), .out_data(norm_data)
  );

  dvr_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(norm_valid), .in_data(norm_data),
    .out_valid(root_valid), .out_data(root_data)
  );

  dvr_divide u_divide (
    .clk(clk), .rst(rst), .en(en), .in_valid(root_valid), .in_data(root_data),
    .out_valid(dir_valid), .out_data(dir_data)
  );

  dvr_predict u_predict (
    .clk(clk), .rst(rst), .en(en), .in_valid(dir_valid), .in_data(dir_data),
    .vel(vel), .out_valid(res_valid), .out_data(res_data)
  );

  assign results.valid          = res_valid;
  assign results.speed_residual = res_data.residual;
  assign results.jac_rot_x      = res_data.rot_x;
  assign results.jac_rot_y      = res_data.rot_y;
  assign results.jac_rot_z      = res_data.rot_z;
  assign results.jac_trans_x    = res_data.trans_x;
  assign results.jac_trans_y    = res_data.trans_y;
  assign results.jac_trans_z    = res_data.trans_z;
endmodule
`default_nettype wire

// File: hw/rtl/dvr_cfg.sv
// APB register file for the ego linear and angular velocity.
`default_nettype none
module dvr_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dvr_pkg::ADDR_W-1:0] paddr,
  input  logic [dvr_pkg::DATA_W-1:0] pwdata,
  output logic [dvr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dvr_pkg::vel_t              vel
);
  import dvr_pkg::*;

  cfg_reg_t idx;
  assign idx    = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vel <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_LIN_VEL_X: vel.lin.x <= pwdata;
        REG_LIN_VEL_Y: vel.lin.y <= pwdata;
        REG_LIN_VEL_Z: vel.lin.z <= pwdata;
        REG_ANG_VEL_X: vel.ang.x <= pwdata;
        REG_ANG_VEL_Y: vel.ang.y <= pwdata;
        REG_ANG_VEL_Z: vel.ang.z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIN_VEL_X: prdata = vel.lin.x;
      REG_LIN_VEL_Y: prdata = vel.lin.y;
      REG_LIN_VEL_Z: prdata = vel.lin.z;
      REG_ANG_VEL_X: prdata = vel.ang.x;
      REG_ANG_VEL_Y: prdata = vel.ang.y;
      REG_ANG_VEL_Z: prdata = vel.ang.z;
      default:       prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/dvr_norm.sv
// Magnitudes, power-of-two normalization and sum of squares (four stages).
`default_nettype none
module dvr_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  dvr_pkg::point_t  pt,
  output logic             out_valid,
  output dvr_pkg::norm_t   out_data
);
  import dvr_pkg::*;

  localparam int HB_W = $clog2(DATA_W);
  localparam logic [HB_W-1:0] TOP_BIT = HB_W'(MAG_W - 1);

  logic a_valid, b_valid, c_valid;
  tag_t a_tag, b_tag, c_tag;
  logic [2:0][DATA_W-1:0]   a_mag;
  logic [2:0][MAG_W-1:0]    b_mag, c_mag;
  logic [2:0][2*MAG_W-1:0]  c_sq;

  logic [2:0][DATA_W-1:0] abs_val;
  logic [2:0]             neg;
  logic [DATA_W-1:0]      mx;
  logic [HB_W-1:0]        hb;
  logic [2:0][MAG_W-1:0]  scaled;

  always_comb begin
    neg = {pt.z[DATA_W-1], pt.y[DATA_W-1], pt.x[DATA_W-1]};
    abs_val[0] = neg[0] ? -pt.x : pt.x;
    abs_val[1] = neg[1] ? -pt.y : pt.y;
    abs_val[2] = neg[2] ? -pt.z : pt.z;
  end

  // largest magnitude, its top bit, then shift it into [2^29, 2^30)
  always_comb begin
    mx = a_mag[0];
    if (a_mag[1] > mx) mx = a_mag[1];
    if (a_mag[2] > mx) mx = a_mag[2];
    hb = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (mx[i]) hb = HB_W'(i);
    end
    for (int i = 0; i < 3; i++) begin
      if (hb > TOP_BIT) scaled[i] = MAG_W'(a_mag[i] >> (hb - TOP_BIT));
      else              scaled[i] = MAG_W'(a_mag[i] << (TOP_BIT - hb));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag.meas <= pt.meas;
      a_tag.neg  <= neg;
      a_tag.zero <= (abs_val == '0);
      a_mag      <= abs_val;
      b_tag      <= a_tag;
      b_mag      <= scaled;
      c_tag      <= b_tag;
      c_mag      <= b_mag;
      for (int i = 0; i < 3; i++) c_sq[i] <= (2*MAG_W)'(b_mag[i]) * (2*MAG_W)'(b_mag[i]);
      out_data.tag <= c_tag;
      out_data.mag <= c_mag;
      out_data.sum <= SUM_W'(c_sq[0]) + SUM_W'(c_sq[1]) + SUM_W'(c_sq[2]);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/dvr_isqrt.sv
// Pipelined integer square root, four bit pairs per stage.
`default_nettype none
module dvr_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  dvr_pkg::norm_t  in_data,
  output logic            out_valid,
  output dvr_pkg::root_t  out_data
);
  import dvr_pkg::*;

  logic                  v   [SQRT_STAGES+1];
  logic [SQ_W-1:0]       x   [SQRT_STAGES+1];
  logic [SQ_W-1:0]       r   [SQRT_STAGES+1];
  logic [2:0][MAG_W-1:0] mg  [SQRT_STAGES+1];
  tag_t                  tg  [SQRT_STAGES+1];

  assign v[0]  = in_valid;
  assign x[0]  = SQ_W'(in_data.sum);
  assign r[0]  = '0;
  assign mg[0] = in_data.mag;
  assign tg[0] = in_data.tag;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [SQ_W-1:0] x_next, r_next;

    always_comb begin
      logic [SQ_W-1:0] bv;
      x_next = x[s];
      r_next = r[s];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        bv = SQ_W'(1) << (SQ_W - 1 - 2 * (s * SQRT_STEPS + k));
        if (x_next >= r_next + bv) begin
          x_next = x_next - (r_next + bv);
          r_next = (r_next >> 1) + bv;
        end else begin
          r_next = r_next >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[s+1]  <= x_next;
        r[s+1]  <= r_next;
        mg[s+1] <= mg[s];
        tg[s+1] <= tg[s];
      end
    end
  end

  assign out_valid     = v[SQRT_STAGES];
  assign out_data.tag  = tg[SQRT_STAGES];
  assign out_data.mag  = mg[SQRT_STAGES];
  assign out_data.root = ROOT_W'(r[SQRT_STAGES]);
endmodule
`default_nettype wire

// File: hw/rtl/dvr_divide.sv
// Three-lane pipelined restoring divider: direction = magnitude / norm, rounded.
`default_nettype none
module dvr_divide (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  dvr_pkg::root_t  in_data,
  output logic            out_valid,
  output dvr_pkg::dir_t   out_data
);
  import dvr_pkg::*;

  localparam int NUM_W = MAG_W + FRAC_W + 1;
  localparam int REM_W = ROOT_W + 1;

  logic                  v   [DIV_STAGES+1];
  logic [2:0][REM_W-1:0] rem [DIV_STAGES+1];
  logic [2:0][QUO_W-1:0] low [DIV_STAGES+1];
  logic [2:0][QUO_W-1:0] quo [DIV_STAGES+1];
  logic [ROOT_W-1:0]     rt  [DIV_STAGES+1];
  tag_t                  tg  [DIV_STAGES+1];

  // numerator mag * 2^FRAC_W + floor(n/2); its top bits start the remainder
  always_comb begin
    logic [NUM_W-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = NUM_W'({in_data.mag[i], FRAC_W'(0)}) + NUM_W'(in_data.root >> 1);
      rem[0][i] = REM_W'(num[NUM_W-1:QUO_W]);
      low[0][i] = num[QUO_W-1:0];
      quo[0][i] = '0;
    end
  end
  assign v[0]  = in_valid;
  assign rt[0] = in_data.root;
  assign tg[0] = in_data.tag;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [2:0][REM_W-1:0] rem_next;
    logic [2:0][QUO_W-1:0] low_next, quo_next;

    always_comb begin
      rem_next = rem[s];
      low_next = low[s];
      quo_next = quo[s];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
          rem_next[i] = {rem_next[i][REM_W-2:0], low_next[i][QUO_W-1]};
          low_next[i] = low_next[i] << 1;
          quo_next[i] = quo_next[i] << 1;
          if (rem_next[i] >= REM_W'(rt[s])) begin
            rem_next[i]    = rem_next[i] - REM_W'(rt[s]);
            quo_next[i][0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_next;
        low[s+1] <= low_next;
        quo[s+1] <= quo_next;
        rt[s+1]  <= rt[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  always_comb begin
    out_valid    = v[DIV_STAGES];
    out_data.tag = tg[DIV_STAGES];
    for (int i = 0; i < 3; i++) begin
      out_data.dir[i] = tg[DIV_STAGES].neg[i] ? -quo[DIV_STAGES][i] : quo[DIV_STAGES][i];
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/dvr_predict.sv
// Offset cross direction, predicted speed, residual and saturated outputs.
`default_nettype none
module dvr_predict (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  dvr_pkg::dir_t    in_data,
  input  dvr_pkg::vel_t    vel,
  output logic             out_valid,
  output dvr_pkg::result_t out_data
);
  import dvr_pkg::*;

  localparam int PR_W   = MOUNT_W + DIR_W;
  localparam int UD_W   = DATA_W + DIR_W;
  localparam int WQ_W   = DATA_W + CROSS_W;
  localparam int ACC_W  = WQ_W + 4;
  localparam int PRED_W = ACC_W - FRAC_W;
  localparam logic signed [PR_W:0]    CROSS_HALF = (PR_W+1)'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF   = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [63:0]      TEN        = 64'sd10;

  logic v1, v2, v3, v4, v5;
  tag_t t1, t2, t3, t4, t5;
  logic signed [DIR_W-1:0]   d  [3];
  logic signed [DIR_W-1:0]   d1 [3];
  logic signed [DIR_W-1:0]   d2 [3];
  logic signed [DIR_W-1:0]   d3 [3];
  logic signed [PR_W-1:0]    pa [3];
  logic signed [PR_W-1:0]    pb [3];
  logic signed [CROSS_W-1:0] q2 [3];
  logic signed [CROSS_W-1:0] q3 [3];
  logic signed [UD_W-1:0]    ud [3];
  logic signed [WQ_W-1:0]    wq [3];
  logic signed [ACC_W-1:0]   su, sw;
  logic signed [PRED_W-1:0]  pred;
  word_t                     u [3];
  word_t                     w [3];
  word_t                     rot4 [3];
  word_t                     trans4 [3];
  word_t                     rot5 [3];
  word_t                     trans5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) d[i] = in_data.dir[i];
    u[0] = vel.lin.x;
    u[1] = vel.lin.y;
    u[2] = vel.lin.z;
    w[0] = vel.ang.x;
    w[1] = vel.ang.y;
    w[2] = vel.ang.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5 && !t5.zero;   // the zero point leaves as a bubble
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offset cross direction products
      t1 <= in_data.tag;
      d1 <= d;
      pa[0] <= MOUNT_Y * d[2];
      pb[0] <= MOUNT_Z * d[1];
      pa[1] <= MOUNT_Z * d[0];
      pb[1] <= MOUNT_X * d[2];
      pa[2] <= MOUNT_X * d[1];
      pb[2] <= MOUNT_Y * d[0];
      // stage 2: round the cross product
      t2 <= t1;
      d2 <= d1;
      for (int i = 0; i < 3; i++) begin
        q2[i] <= CROSS_W'(((PR_W+1)'(pa[i]) - (PR_W+1)'(pb[i]) + CROSS_HALF) >>> FRAC_W);
      end
      // stage 3: velocity products
      t3 <= t2;
      d3 <= d2;
      q3 <= q2;
      for (int i = 0; i < 3; i++) begin
        ud[i] <= u[i] * UD_W'(d2[i]);
        wq[i] <= w[i] * WQ_W'(q2[i]);
      end
      // stage 4: dot products and the Jacobian
      t4 <= t3;
      su <= ACC_W'(ud[0]) + ACC_W'(ud[1]) + ACC_W'(ud[2]);
      sw <= ACC_W'(wq[0]) + ACC_W'(wq[1]) + ACC_W'(wq[2]);
      for (int i = 0; i < 3; i++) begin
        rot4[i]   <= saturate(-(64'(q3[i]) * TEN));
        trans4[i] <= saturate(-(64'(d3[i]) * TEN));
      end
      // stage 5: round the prediction once
      t5     <= t4;
      rot5   <= rot4;
      trans5 <= trans4;
      pred   <= PRED_W'((su - sw + ACC_HALF) >>> FRAC_W);
      // stage 6: output register
      out_data.residual <= saturate(64'(t5.meas) - 64'(pred));
      out_data.rot_x    <= rot5[0];
      out_data.rot_y    <= rot5[1];
      out_data.rot_z    <= rot5[2];
      out_data.trans_x  <= trans5[0];
      out_data.trans_y  <= trans5[1];
      out_data.trans_z  <= trans5[2];
    end
  end
endmodule
`default_nettype wire
